// ===== rtl/core/cfp_pkg.sv =====
package cfp_pkg;

    // Frame delimiters and fixed payload size.
    localparam logic [7:0] SOF_BYTE      = 8'hAA;
    localparam logic [7:0] EOF_BYTE      = 8'h55;
    localparam int         PAYLOAD_BYTES = 6;
    localparam int         CNT_W         = 3;

    // Configuration port.
    localparam int         CFG_IDX_W = 2;
    localparam int         CFG_DAT_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_COMMAND     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_CONTROL_ENABLE = 2'd2;

    localparam logic [7:0] RST_EXPECTED_LENGTH     = 8'd7;
    localparam logic [7:0] RST_CONTROL_COMMAND     = 8'h20;
    localparam logic       RST_HOST_CONTROL_ENABLE = 1'b1;

    typedef struct packed {
        logic [7:0] expected_length;
        logic [7:0] control_command;
        logic       host_control_enable;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_z;
    } vel_t;

endpackage

// ===== rtl/core/cfp_byte_if.sv =====
interface cfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/cfp_vel_if.sv =====
interface cfp_vel_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;

    modport source (output valid, output vel_x, output vel_y, output vel_z, input ready);
    modport sink   (input valid, input vel_x, input vel_y, input vel_z, output ready);
endinterface

// ===== rtl/core/cfp_parser.sv =====
module cfp_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_take,
    input  logic [7:0]          byte_data,
    input  cfp_pkg::cfg_t       cfg,
    output logic                res_valid,
    output cfp_pkg::vel_t       res
);

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_CMD   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CHECK = 3'd4;
    localparam logic [2:0] PH_END   = 3'd5;

    logic [2:0]                 phase_reg, phase_next;
    logic [7:0]                 check_reg, check_next;
    logic [7:0]                 length_reg, length_next;
    logic [cfp_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [cfp_pkg::CNT_W-1:0]  count_inc;
    logic [7:0]                 payload_reg [cfp_pkg::PAYLOAD_BYTES];
    logic                       store_en;

    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        phase_next  = phase_reg;
        check_next  = check_reg;
        length_next = length_reg;
        count_next  = count_reg;
        store_en    = 1'b0;
        res_valid   = 1'b0;
        case (phase_reg)
            PH_LEN:
            begin
                length_next = byte_data;
                check_next  = check_reg ^ byte_data;
                phase_next  = PH_CMD;
            end
            PH_CMD:
            begin
                check_next = check_reg ^ byte_data;
                count_next = '0;
                if (length_reg == cfg.expected_length && byte_data == cfg.control_command)
                    phase_next = PH_DATA;
                else
                    phase_next = PH_HUNT;
            end
            PH_DATA:
            begin
                store_en   = (count_reg < cfp_pkg::CNT_W'(cfp_pkg::PAYLOAD_BYTES));
                check_next = check_reg ^ byte_data;
                count_next = count_inc;
                if (count_inc >= cfp_pkg::CNT_W'(cfp_pkg::PAYLOAD_BYTES))
                    phase_next = PH_CHECK;
            end
            PH_CHECK:
            begin
                phase_next = (byte_data == check_reg) ? PH_END : PH_HUNT;
            end
            PH_END:
            begin
                res_valid  = (byte_data == cfp_pkg::EOF_BYTE) && cfg.host_control_enable;
                phase_next = PH_HUNT;
            end
            default:
            begin
                if (byte_data == cfp_pkg::SOF_BYTE)
                begin
                    phase_next = PH_LEN;
                    check_next = '0;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    assign res.vel_x = {payload_reg[1], payload_reg[0]};
    assign res.vel_y = {payload_reg[3], payload_reg[2]};
    assign res.vel_z = {payload_reg[5], payload_reg[4]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            check_reg  <= '0;
            length_reg <= '0;
            count_reg  <= '0;
        end
        else if (byte_take)
        begin
            phase_reg  <= phase_next;
            check_reg  <= check_next;
            length_reg <= length_next;
            count_reg  <= count_next;
        end
    end

    // Payload bytes need no reset: each is written before the frame can complete.
    always_ff @(posedge clk)
    begin
        if (byte_take && store_en)
            payload_reg[count_reg] <= byte_data;
    end

endmodule

// ===== rtl/core/cfp_out_buf.sv =====
module cfp_out_buf
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cfp_pkg::vel_t  push_data,
    output logic           space,
    output logic           out_valid,
    input  logic           out_ready,
    output cfp_pkg::vel_t  out_data
);

    logic           main_valid_reg;
    logic           skid_valid_reg;
    cfp_pkg::vel_t  main_data_reg;
    cfp_pkg::vel_t  skid_data_reg;
    logic           pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
                main_data_reg <= push_data;
            else
                skid_data_reg <= push_data;
        end
    end

endmodule

// ===== rtl/core/control_frame_parser.sv =====
// Control frame parser. Received serial words (one byte each) enter on rx and are
// parsed as start 0xAA, length, command, six payload bytes, XOR check and end 0x55;
// a frame whose length and command match the configured values, whose check byte
// equals the XOR of length, command and payload, and which ends in 0x55 yields one
// word on vel with three little-endian signed 16-bit velocities, provided host
// control is enabled. Every other byte pattern yields nothing and the parser goes
// back to hunting for a start byte; a byte that ends a frame is never reused as a
// start. The block takes one byte per clock: each byte goes through one small state
// transition, and a result is held in a two-entry output buffer, so rx stays ready
// while a result waits on vel and stalls only when both entries are full. A result appears
// on vel at the earliest the cycle after its end byte is accepted, later if an earlier result
// still waits there. Configuration registers (0 expected length, 1 control command, 2 host
// control enable) are written through cfg_we, cfg_index and cfg_data; other indexes are
// ignored. The user must write them only while the block is idle; this is not enforced.
module control_frame_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    cfp_byte_if.sink                            rx,
    cfp_vel_if.source                           vel,
    input  logic                                cfg_we,
    input  logic [cfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cfp_pkg::CFG_DAT_W-1:0]       cfg_data
);

    cfp_pkg::cfg_t  cfg_reg;
    logic           byte_take;
    logic           res_valid;
    cfp_pkg::vel_t  res;
    logic           space;
    cfp_pkg::vel_t  out_data;

    // Configuration registers; writes are masked to each register's width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_length     <= cfp_pkg::RST_EXPECTED_LENGTH;
            cfg_reg.control_command     <= cfp_pkg::RST_CONTROL_COMMAND;
            cfg_reg.host_control_enable <= cfp_pkg::RST_HOST_CONTROL_ENABLE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cfp_pkg::CFG_EXPECTED_LENGTH:     cfg_reg.expected_length     <= cfg_data;
                cfp_pkg::CFG_CONTROL_COMMAND:     cfg_reg.control_command     <= cfg_data;
                cfp_pkg::CFG_HOST_CONTROL_ENABLE: cfg_reg.host_control_enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // A byte is taken whenever the output buffer can absorb a possible result.
    assign rx.ready  = space;
    assign byte_take = rx.valid && space;

    cfp_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_take (byte_take),
        .byte_data (rx.rx_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    cfp_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (byte_take && res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (vel.valid),
        .out_ready (vel.ready),
        .out_data  (out_data)
    );

    assign vel.vel_x = out_data.vel_x;
    assign vel.vel_y = out_data.vel_y;
    assign vel.vel_z = out_data.vel_z;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the control frame parser.
//
// Bytes go in on the rx channel one word at a time, and each accepted byte is
// also run through a bench-side copy of the parser. Whenever that copy sees a
// complete, valid frame while host control is enabled, it queues the velocity
// word that the block must produce. A separate checker pops that queue each
// time a word is accepted on the vel channel and compares every field.
module testbench;

    // Parser steps of the bench-side model. The block's own encoding is not
    // visible, so these only need to be distinct.
    typedef enum logic [2:0] {
        HUNT_SOF,
        TAKE_LEN,
        TAKE_CMD,
        TAKE_PAYLOAD,
        TAKE_CHECK,
        TAKE_EOF
    } frame_step_t;

    // Ways a generated frame can be damaged on its way to the block.
    typedef enum int {
        FAULT_NONE,
        FAULT_LEN,
        FAULT_CMD,
        FAULT_CHECK,
        FAULT_EOF,
        FAULT_TRUNC
    } frame_fault_t;

    // The one index the port can carry that maps to no register.
    localparam logic [cfp_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    // A result is registered in the output buffer after its end byte is taken. The
    // slack covers the output buffer before a register write or the end of the run.
    localparam int LATENCY_SLACK = 8;

    // Bytes that belong to frames in the random part, and the share of one
    // register setting.
    localparam int RANDOM_FRAME_BYTES = 900;
    localparam int PHASE_BYTES        = 130;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [cfp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cfp_pkg::CFG_DAT_W-1:0] cfg_data;

    cfp_byte_if rx_if ();
    cfp_vel_if  vel_if ();

    control_frame_parser dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_if),
        .vel       (vel_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Bench copy of the configuration registers.
    logic [7:0] want_length;
    logic [7:0] want_command;
    logic       want_host_enable;

    // Bench copy of the parser state.
    frame_step_t rx_step;
    logic [7:0]  check_acc;
    logic [7:0]  length_byte;
    logic [7:0]  payload_q [0:cfp_pkg::PAYLOAD_BYTES-1];
    logic [2:0]  payload_cnt;

    // Velocity words still owed by the block, oldest first.
    cfp_pkg::vel_t expected_vel [$];

    // Idle controls for the two sides; phases turn them on and off.
    bit src_gaps_on;
    bit sink_stalls_on;

    int fail_count;
    int frames_sent;
    int frame_bytes;
    int bytes_accepted;
    int vel_checked;
    int settings_used;

    // Most idle stretches are short; a few are long enough to back the output
    // buffer up or leave the parser waiting in the middle of a frame.
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the bench parser by one accepted byte. A velocity word is
    // queued only on a correct end byte while host control is enabled.
    function automatic void track_byte(input logic [7:0] b);
        cfp_pkg::vel_t v;
        case (rx_step)
            TAKE_LEN:
            begin
                length_byte = b;
                check_acc   = check_acc ^ b;
                rx_step     = TAKE_CMD;
            end
            TAKE_CMD:
            begin
                // The frame survives only if both length and command match.
                check_acc   = check_acc ^ b;
                payload_cnt = '0;
                if (length_byte == want_length && b == want_command)
                    rx_step = TAKE_PAYLOAD;
                else
                    rx_step = HUNT_SOF;
            end
            TAKE_PAYLOAD:
            begin
                // Exactly six payload bytes, whatever the length byte said.
                payload_q[payload_cnt] = b;
                check_acc   = check_acc ^ b;
                payload_cnt = payload_cnt + 3'd1;
                if (payload_cnt >= cfp_pkg::PAYLOAD_BYTES)
                    rx_step = TAKE_CHECK;
            end
            TAKE_CHECK:
            begin
                rx_step = (b == check_acc) ? TAKE_EOF : HUNT_SOF;
            end
            TAKE_EOF:
            begin
                // Any byte here ends the frame and is not looked at again as a
                // possible start byte.
                if (b == cfp_pkg::EOF_BYTE && want_host_enable)
                begin
                    v.vel_x = {payload_q[1], payload_q[0]};
                    v.vel_y = {payload_q[3], payload_q[2]};
                    v.vel_z = {payload_q[5], payload_q[4]};
                    expected_vel.push_back(v);
                end
                rx_step = HUNT_SOF;
            end
            default:
            begin
                if (b == cfp_pkg::SOF_BYTE)
                begin
                    rx_step   = TAKE_LEN;
                    check_acc = '0;
                end
            end
        endcase
    endfunction

    // Offer one byte on rx, after a random gap, and hold it until it is taken.
    // Valid is left high afterward so that back-to-back bytes never see valid
    // lowered and raised in the same time step; a gap or a drain lowers it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_gaps_on ? pick_idle_len() : 0;
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        track_byte(b);
        bytes_accepted++;
        @(negedge clk);
    endtask

    // Build a frame for the given length and command, damage it as asked, and
    // send it. The check byte is computed over the bytes actually sent, so
    // only the damage that was asked for can make the frame fail. A truncated
    // frame stops somewhere between its start byte and its end byte.
    task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
                              input logic [47:0] payload, input frame_fault_t fault,
                              input logic [7:0] bad);
        logic [7:0] fb [0:10];
        logic [7:0] chk;
        int n;
        fb[0] = cfp_pkg::SOF_BYTE;
        fb[1] = (fault == FAULT_LEN) ? bad : len;
        fb[2] = (fault == FAULT_CMD) ? bad : cmd;
        chk   = fb[1] ^ fb[2];
        for (int i = 0; i < cfp_pkg::PAYLOAD_BYTES; i++)
        begin
            fb[3 + i] = payload[8 * i +: 8];
            chk       = chk ^ fb[3 + i];
        end
        fb[9]  = (fault == FAULT_CHECK) ? bad : chk;
        fb[10] = (fault == FAULT_EOF) ? bad : cfp_pkg::EOF_BYTE;
        n = (fault == FAULT_TRUNC) ? 1 + (bad % 10) : 11;
        for (int i = 0; i < n; i++)
            send_byte(fb[i]);
        frames_sent++;
        frame_bytes += n;
    endtask

    // Stop sending, wait for every owed word, then let the block settle. Only
    // after this is the block idle enough for register writes.
    task automatic drain_and_settle();
        rx_if.valid <= 1'b0;
        while (expected_vel.size() != 0)
            @(posedge clk);
        repeat (LATENCY_SLACK) @(posedge clk);
        @(negedge clk);
    endtask

    // One register write. The write enable is left high so that consecutive
    // writes run back to back; program_config lowers it after the last one.
    task automatic write_reg(input logic [cfp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            cfp_pkg::CFG_EXPECTED_LENGTH:     want_length      = data;
            cfp_pkg::CFG_CONTROL_COMMAND:     want_command     = data;
            cfp_pkg::CFG_HOST_CONTROL_ENABLE: want_host_enable = data[0];
            default:                          ;
        endcase
        @(negedge clk);
    endtask

    // Write all three registers, then a random value to the unused index,
    // which the block must ignore. Only bit 0 of the enable data counts.
    task automatic program_config(input logic [7:0] len, input logic [7:0] cmd,
                                  input logic [7:0] enable_data);
        write_reg(cfp_pkg::CFG_EXPECTED_LENGTH, len);
        write_reg(cfp_pkg::CFG_CONTROL_COMMAND, cmd);
        write_reg(cfp_pkg::CFG_HOST_CONTROL_ENABLE, enable_data);
        write_reg(CFG_UNUSED_INDEX, 8'($urandom_range(0, 255)));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Register values lean on the extremes and the reset values.
    function automatic logic [7:0] pick_reg_value(input logic [7:0] reset_value);
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 8'h00;
        if (r < 40)
            return 8'hFF;
        if (r < 60)
            return reset_value;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [47:0] pick_payload();
        logic [47:0] p;
        p = 48'({$urandom, $urandom});
        case ($urandom_range(0, 19))
            0: p = 48'h0000_0000_0000;
            1: p = 48'hFFFF_FFFF_FFFF;
            2: p = 48'h8000_8000_8000;
            3: p = 48'h7FFF_7FFF_7FFF;
            default: ;
        endcase
        return p;
    endfunction

    // Mostly clean frames, so that most traffic gets through to the end byte.
    function automatic frame_fault_t pick_fault();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return FAULT_NONE;
        if (r < 72)
            return FAULT_LEN;
        if (r < 79)
            return FAULT_CMD;
        if (r < 86)
            return FAULT_CHECK;
        if (r < 93)
            return FAULT_EOF;
        return FAULT_TRUNC;
    endfunction

    // Receiver side: random stalls on vel.ready, applied at the falling edge.
    initial
    begin : vel_sink
        int stall_left;
        vel_if.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                vel_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                vel_if.ready <= 1'b1;
                if (sink_stalls_on)
                    stall_left = pick_idle_len();
            end
        end
    end

    // Checker: every accepted velocity word must match the oldest one owed.
    always @(posedge clk)
    begin : vel_checker
        cfp_pkg::vel_t want;
        if (rst_n && vel_if.valid && vel_if.ready)
        begin
            if (expected_vel.size() == 0)
            begin
                $error("velocity word with none expected: x=%0d y=%0d z=%0d",
                       vel_if.vel_x, vel_if.vel_y, vel_if.vel_z);
                fail_count++;
            end
            else
            begin
                want = expected_vel.pop_front();
                if (vel_if.vel_x !== want.vel_x)
                begin
                    $error("vel_x mismatch: expected %0d, actual %0d",
                           want.vel_x, vel_if.vel_x);
                    fail_count++;
                end
                if (vel_if.vel_y !== want.vel_y)
                begin
                    $error("vel_y mismatch: expected %0d, actual %0d",
                           want.vel_y, vel_if.vel_y);
                    fail_count++;
                end
                if (vel_if.vel_z !== want.vel_z)
                begin
                    $error("vel_z mismatch: expected %0d, actual %0d",
                           want.vel_z, vel_if.vel_z);
                    fail_count++;
                end
                vel_checked++;
            end
        end
    end

    // Reset configuration: a clean frame whose payload hits the signed extremes,
    // plus one carrying start and end byte values inside the payload.
    task automatic test_reset_frames();
        send_frame(cfp_pkg::RST_EXPECTED_LENGTH, cfp_pkg::RST_CONTROL_COMMAND,
                   48'hFFFF_7FFF_8000, FAULT_NONE, 8'h00);
        send_frame(cfp_pkg::RST_EXPECTED_LENGTH, cfp_pkg::RST_CONTROL_COMMAND,
                   48'h00AA_0055_0001, FAULT_NONE, 8'h00);
    endtask

    // Each way a frame can be rejected. In the length, command, check and end faults
    // the damaged byte is a start byte value, which must be consumed rather than taken
    // as a new frame. The clean frame at the end is parsed as the rest of the truncated one.
    task automatic test_rejected_frames();
        send_frame(want_length, want_command, 48'h1111_2222_3333, FAULT_LEN,
                   cfp_pkg::SOF_BYTE);
        send_frame(want_length, want_command, 48'h1111_2222_3333, FAULT_CMD,
                   cfp_pkg::SOF_BYTE);
        send_frame(want_length, want_command, 48'h4444_5555_6666, FAULT_CHECK,
                   cfp_pkg::SOF_BYTE);
        send_frame(want_length, want_command, 48'h7777_8888_9999, FAULT_EOF,
                   cfp_pkg::SOF_BYTE);
        send_frame(want_length, want_command, 48'h0102_0304_0506, FAULT_TRUNC, 8'd5);
        send_frame(want_length, want_command, 48'hFEDC_BA98_7654, FAULT_NONE, 8'h00);
    endtask

    // Register extremes. A length of 255 still takes six payload bytes. The
    // enable write with every bit but bit 0 set must turn host control off,
    // so the clean frame after it is parsed but yields nothing.
    task automatic test_register_extremes();
        drain_and_settle();
        program_config(8'h00, 8'h00, 8'h01);
        send_frame(8'h00, 8'h00, 48'h8001_7FFE_0080, FAULT_NONE, 8'h00);
        drain_and_settle();
        program_config(8'hFF, 8'hFF, 8'h01);
        send_frame(8'hFF, 8'hFF, 48'hFFFF_0000_FFFF, FAULT_NONE, 8'h00);
        drain_and_settle();
        program_config(cfp_pkg::RST_EXPECTED_LENGTH, cfp_pkg::RST_CONTROL_COMMAND, 8'hFE);
        send_frame(cfp_pkg::RST_EXPECTED_LENGTH, cfp_pkg::RST_CONTROL_COMMAND,
                   48'h1234_5678_9ABC, FAULT_NONE, 8'h00);
        drain_and_settle();
        program_config(cfp_pkg::RST_EXPECTED_LENGTH, cfp_pkg::RST_CONTROL_COMMAND, 8'h01);
        send_frame(cfp_pkg::RST_EXPECTED_LENGTH, cfp_pkg::RST_CONTROL_COMMAND,
                   48'hCAFE_0BAD_F00D, FAULT_NONE, 8'h00);
    endtask

    // Random traffic in phases, one register setting per phase. The first
    // phase runs with no idling at all, the second idles only the sender, and
    // the rest idle both sides. Noise bytes fall between frames now and then.
    task automatic test_random_traffic();
        int phase;
        int start_bytes;
        int random_bytes;
        logic [7:0] enable_data;
        phase        = 0;
        random_bytes = 0;
        while (random_bytes < RANDOM_FRAME_BYTES)
        begin
            drain_and_settle();
            src_gaps_on    = (phase != 0);
            sink_stalls_on = (phase > 1);
            enable_data    = 8'($urandom_range(0, 255));
            enable_data[0] = ($urandom_range(0, 99) < 80);
            program_config(pick_reg_value(cfp_pkg::RST_EXPECTED_LENGTH),
                           pick_reg_value(cfp_pkg::RST_CONTROL_COMMAND), enable_data);
            start_bytes = frame_bytes;
            while (frame_bytes - start_bytes < PHASE_BYTES)
            begin
                if ($urandom_range(0, 99) < 15)
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                send_frame(want_length, want_command, pick_payload(), pick_fault(),
                           8'($urandom_range(0, 255)));
            end
            random_bytes += frame_bytes - start_bytes;
            phase++;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;

        want_length      = cfp_pkg::RST_EXPECTED_LENGTH;
        want_command     = cfp_pkg::RST_CONTROL_COMMAND;
        want_host_enable = cfp_pkg::RST_HOST_CONTROL_ENABLE;
        rx_step          = HUNT_SOF;
        check_acc        = '0;
        length_byte      = '0;
        payload_cnt      = '0;
        for (int i = 0; i < cfp_pkg::PAYLOAD_BYTES; i++)
            payload_q[i] = '0;

        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        fail_count     = 0;
        frames_sent    = 0;
        frame_bytes    = 0;
        bytes_accepted = 0;
        vel_checked    = 0;
        settings_used  = 1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_frames();
        test_rejected_frames();
        test_register_extremes();
        test_random_traffic();
        drain_and_settle();

        $display("Sent %0d frames (%0d bytes accepted) over %0d register settings.",
                 frames_sent, bytes_accepted, settings_used);
        $display("Checked %0d velocity words; %0d mismatches.", vel_checked, fail_count);
        if (fail_count == 0)
            $display("[control_frame_parser] OK");
        else
            $display("[control_frame_parser] ERROR");
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("[control_frame_parser] ERROR");
        $finish;
    end

endmodule
